/* hdl/tfp_pkg.sv */
package tfp_pkg;

    localparam int MAX_TLVS = 16;
    localparam int CNT_W = $clog2(MAX_TLVS + 1);
    localparam logic [CNT_W-1:0] MAX_TLVS_C = CNT_W'(MAX_TLVS);

    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [7:0] CKSUM_TYPE_RESET = 8'hFF;

    localparam logic [2:0] ST_RUNNING  = 3'd0;
    localparam logic [2:0] ST_OK       = 3'd1;
    localparam logic [2:0] ST_TOO_MANY = 3'd2;
    localparam logic [2:0] ST_TRUNC    = 3'd3;
    localparam logic [2:0] ST_MISMATCH = 3'd4;
    localparam logic [2:0] ST_DISCARD  = 3'd5;

    typedef enum logic [1:0] {
        PH_TYPE,
        PH_LEN_HI,
        PH_LEN_LO,
        PH_VALUE
    } phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_message;
    } in_item_t;

    // reflected crc-32, one byte
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'h0, b};
        for (int k = 0; k < 8; k++)
        begin
            c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'h0);
        end
        return c;
    endfunction

endpackage

/* hdl/tfp_if.sv */
interface tlv_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_message;

    modport source (output valid, output data_byte, output end_of_message, input ready);
    modport sink (input valid, input data_byte, input end_of_message, output ready);
endinterface

interface tlv_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [7:0]  tlv_type;
    logic [15:0] value_length;
    logic [3:0]  tlv_index;
    logic [7:0]  value_byte;
    logic        value_valid;
    logic        tlv_done;

    modport source (output valid, output status, output tlv_type, output value_length,
                    output tlv_index, output value_byte, output value_valid,
                    output tlv_done, input ready);
    modport sink (input valid, input status, input tlv_type, input value_length,
                  input tlv_index, input value_byte, input value_valid,
                  input tlv_done, output ready);
endinterface

/* hdl/tlv_frame_parser_crc32_core.sv */
// a byte is registered in the input stage, then parsed and its result held in the output register
// throughput: one byte per cycle while results are taken, set by the single parse/crc stage
// the input register lets a new byte in while a result still waits
// reset (rst_n low, async): parser at start of message, crc all ones,
// checksum type register back to 255, no result pending
module tlv_frame_parser_crc32_core
    import tfp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    tlv_in_if.sink     msg,
    tlv_out_if.source  res,
    input  logic       cfg_wr_en,
    input  logic [7:0] cfg_wr_data
);

    logic [7:0] cksum_type_reg;
    logic       q_valid;
    in_item_t   q_item;
    logic       take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cksum_type_reg <= CKSUM_TYPE_RESET;
        end
        else if (cfg_wr_en)
        begin
            cksum_type_reg <= cfg_wr_data;
        end
    end

    tfp_in_stage u_in_stage (
        .clk     (clk),
        .rst_n   (rst_n),
        .msg     (msg),
        .take    (take),
        .q_valid (q_valid),
        .q_item  (q_item)
    );

    tfp_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .cksum_type (cksum_type_reg),
        .take       (take),
        .res        (res)
    );

    a_value_not_in_error: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.value_valid |-> res.status != ST_DISCARD && res.status != ST_TOO_MANY)
        else $error("value byte passed during discard or tlv overflow");

    a_error_fields_clear: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && (res.status == ST_DISCARD || res.status == ST_TOO_MANY)
        |-> res.tlv_type == 8'h00 && res.value_length == 16'h0000 && res.tlv_index == 4'h0)
        else $error("tlv fields not cleared on discard or overflow");

    a_mismatch_on_done: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && (res.status == ST_MISMATCH || res.status == ST_OK) |-> res.tlv_done)
        else $error("ok or mismatch reported on a byte that does not end a tlv");

    a_take_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        take |-> q_valid && (!res.valid || res.ready))
        else $error("parser step without a pending byte or with a blocked result");

endmodule

/* hdl/tfp_in_stage.sv */
module tfp_in_stage
    import tfp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    tlv_in_if.sink   msg,
    input  logic     take,
    output logic     q_valid,
    output in_item_t q_item
);

    logic     valid_reg;
    in_item_t item_reg;

    assign msg.ready = !valid_reg || take;
    assign q_valid   = valid_reg;
    assign q_item    = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (msg.ready)
        begin
            valid_reg <= msg.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (msg.ready && msg.valid)
        begin
            item_reg <= '{data_byte: msg.data_byte, end_of_message: msg.end_of_message};
        end
    end

endmodule

/* hdl/tfp_parser.sv */
module tfp_parser
    import tfp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_valid,
    input  in_item_t   q_item,
    input  logic [7:0] cksum_type,
    output logic       take,
    tlv_out_if.source  res
);

    phase_t            phase_reg, phase_next;
    logic [7:0]        type_reg, type_next;
    logic [15:0]       len_reg, len_next;
    logic [15:0]       rem_reg, rem_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [31:0]       crc_reg, crc_next;
    logic [31:0]       snap_reg, snap_next;
    logic [2:0]        chk_idx_reg, chk_idx_next;
    logic              fail_reg, fail_next;
    logic              discard_reg, discard_next;

    logic              out_valid_reg;
    logic [2:0]        status_reg, status_next;
    logic [7:0]        otype_reg, otype_next;
    logic [15:0]       olen_reg, olen_next;
    logic [3:0]        oidx_reg, oidx_next;
    logic [7:0]        vb_reg, vb_next;
    logic              vv_reg, vv_next;
    logic              done_reg, done_next;

    logic [CNT_W+3:0]  count_ext;
    logic [7:0]        b;
    logic              eom;
    logic              clear;
    logic              mismatch;
    logic [7:0]        snap_sel;

    assign take = q_valid && (!out_valid_reg || res.ready);
    assign b    = q_item.data_byte;
    assign eom  = q_item.end_of_message;
    assign count_ext = {4'h0, count_reg};

    always_comb
    begin
        case (chk_idx_reg)
            3'd0: snap_sel = snap_reg[31:24];
            3'd1: snap_sel = snap_reg[23:16];
            3'd2: snap_sel = snap_reg[15:8];
            3'd3: snap_sel = snap_reg[7:0];
            default: snap_sel = 8'h00;
        endcase
    end

    always_comb
    begin
        phase_next   = phase_reg;
        type_next    = type_reg;
        len_next     = len_reg;
        rem_next     = rem_reg;
        count_next   = count_reg;
        crc_next     = crc_reg;
        snap_next    = snap_reg;
        chk_idx_next = chk_idx_reg;
        fail_next    = fail_reg;
        discard_next = discard_reg;
        status_next  = ST_RUNNING;
        otype_next   = 8'h00;
        olen_next    = 16'h0000;
        oidx_next    = 4'h0;
        vb_next      = 8'h00;
        vv_next      = 1'b0;
        done_next    = 1'b0;
        clear        = 1'b0;
        mismatch     = 1'b0;

        if (discard_reg)
        begin
            status_next = ST_DISCARD;
            clear       = eom;
        end
        else if (phase_reg == PH_TYPE)
        begin
            if (count_reg >= MAX_TLVS_C)
            begin
                status_next = ST_TOO_MANY;
                clear       = eom;
                discard_next = !eom;
            end
            else
            begin
                type_next    = b;
                len_next     = 16'h0000;
                rem_next     = 16'h0000;
                chk_idx_next = 3'd0;
                fail_next    = 1'b0;
                snap_next    = ~crc_reg;
                phase_next   = PH_LEN_HI;
                otype_next   = b;
                oidx_next    = count_ext[3:0];
                if (eom)
                begin
                    status_next = ST_TRUNC;
                    clear       = 1'b1;
                end
            end
        end
        else
        begin
            otype_next = type_reg;
            oidx_next  = count_ext[3:0];
            case (phase_reg)
                PH_LEN_HI:
                begin
                    len_next   = {b, 8'h00};
                    phase_next = PH_LEN_LO;
                end
                PH_LEN_LO:
                begin
                    len_next = {len_reg[15:8], b};
                    rem_next = {len_reg[15:8], b};
                    if ({len_reg[15:8], b} == 16'h0000)
                    begin
                        done_next = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_VALUE;
                    end
                end
                default:
                begin
                    vv_next  = 1'b1;
                    vb_next  = b;
                    crc_next = crc_byte(crc_reg, b);
                    if (chk_idx_reg < 3'd4)
                    begin
                        if (snap_sel != b)
                        begin
                            fail_next = 1'b1;
                        end
                        chk_idx_next = chk_idx_reg + 3'd1;
                    end
                    rem_next = rem_reg - 16'd1;
                    if (rem_reg == 16'd1)
                    begin
                        done_next = 1'b1;
                    end
                end
            endcase
            olen_next = len_next;

            if (done_next)
            begin
                // checksum tlv needs all four bytes present and equal
                mismatch   = (type_reg == cksum_type) && (fail_next || chk_idx_next < 3'd4);
                count_next = count_reg + 1'b1;
                phase_next = PH_TYPE;
                if (mismatch)
                begin
                    status_next  = ST_MISMATCH;
                    clear        = eom;
                    discard_next = !eom;
                end
                else if (eom)
                begin
                    status_next = ST_OK;
                    clear       = 1'b1;
                end
            end
            else if (eom)
            begin
                status_next = ST_TRUNC;
                clear       = 1'b1;
            end
        end

        // end of message: back to the start-of-message state
        if (clear)
        begin
            phase_next   = PH_TYPE;
            type_next    = 8'h00;
            len_next     = 16'h0000;
            rem_next     = 16'h0000;
            count_next   = '0;
            crc_next     = 32'hFFFF_FFFF;
            snap_next    = 32'h0000_0000;
            chk_idx_next = 3'd0;
            fail_next    = 1'b0;
            discard_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_TYPE;
            type_reg      <= 8'h00;
            len_reg       <= 16'h0000;
            rem_reg       <= 16'h0000;
            count_reg     <= '0;
            crc_reg       <= 32'hFFFF_FFFF;
            snap_reg      <= 32'h0000_0000;
            chk_idx_reg   <= 3'd0;
            fail_reg      <= 1'b0;
            discard_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                phase_reg   <= phase_next;
                type_reg    <= type_next;
                len_reg     <= len_next;
                rem_reg     <= rem_next;
                count_reg   <= count_next;
                crc_reg     <= crc_next;
                snap_reg    <= snap_next;
                chk_idx_reg <= chk_idx_next;
                fail_reg    <= fail_next;
                discard_reg <= discard_next;
            end
            if (take)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            status_reg <= status_next;
            otype_reg  <= otype_next;
            olen_reg   <= olen_next;
            oidx_reg   <= oidx_next;
            vb_reg     <= vb_next;
            vv_reg     <= vv_next;
            done_reg   <= done_next;
        end
    end

    assign res.valid        = out_valid_reg;
    assign res.status       = status_reg;
    assign res.tlv_type     = otype_reg;
    assign res.value_length = olen_reg;
    assign res.tlv_index    = oidx_reg;
    assign res.value_byte   = vb_reg;
    assign res.value_valid  = vv_reg;
    assign res.tlv_done     = done_reg;

endmodule
